### design/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// shared types and constants of the line pixel rasterizer
// ----------------------------------------------------------------------------
package lpr_pkg;

    // fixed field widths
    localparam int ADDR_BITS  = 32;
    localparam int WIDTH_BITS = 10;
    localparam int COLOR_BITS = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [WIDTH_BITS-1:0] IMAGE_WIDTH_RESET = WIDTH_BITS'(480);

    // command codes
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_cmd;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_BASE  = 1'b0,
        REG_IMAGE_WIDTH = 1'b1
    } t_reg_index;

    // axis direction codes
    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_PLUS  = 2'd1,
        DIR_MINUS = 2'd3
    } t_dir;

endpackage

### design/lpr_if.sv
// ----------------------------------------------------------------------------
// lpr_if
// valid/ready channels carrying command words and pixel words
// ----------------------------------------------------------------------------

// command channel
interface lpr_cmd_if
    import lpr_pkg::*;
#(
    parameter int COORD_BITS = 10
) ();
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] pen_color;

    modport source (
        output valid, cmd, x_start, y_start, x_end, y_end, pen_color,
        input  ready
    );
    modport sink (
        input  valid, cmd, x_start, y_start, x_end, y_end, pen_color,
        output ready
    );
endinterface

// pixel channel
interface lpr_pix_if
    import lpr_pkg::*;
#(
    parameter int COORD_BITS = 10
) ();
    logic                  valid;
    logic                  ready;
    logic [ADDR_BITS-1:0]  pixel_address;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_pixel;

    modport source (
        output valid, pixel_address, pixel_x, pixel_y, pixel_color, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_address, pixel_x, pixel_y, pixel_color, last_pixel,
        output ready
    );
endinterface

### design/line_pixel_rasterizer.sv
// ----------------------------------------------------------------------------
// line_pixel_rasterizer
// dda line rasterizer: a start word latches two endpoints and a color and
// gives the first pixel; each step word gives the next pixel of the line
// until the last one, flagged by last_pixel. Every pixel carries its
// framebuffer byte address base + 2 * (y * width + x), wrapping at 32 bits.
// A start word while a line runs restarts; a step word while idle gives no
// pixel. One command word is taken every cycle unless the pixel stage stalls:
// the stepper updates the error for both axes combinationally, and the address
// multiply-add sits in a second registered stage; the block sustains one
// pixel per cycle unless the output stalls. The user must write the
// configuration registers only while no line work is pending; the block does not enforce it.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer
    import lpr_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [ADDR_BITS-1:0]      i_cfg_data,
    // command words in, pixel words out
    lpr_cmd_if.sink                   i_cmd,
    lpr_pix_if.source                 o_pixel
);

    logic [ADDR_BITS-1:0]  r_frame_base;
    logic [WIDTH_BITS-1:0] r_image_width;

    logic                  s1_valid;
    logic                  s1_ready;
    logic [COORD_BITS-1:0] s1_x;
    logic [COORD_BITS-1:0] s1_y;
    logic [COLOR_BITS-1:0] s1_color;
    logic                  s1_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base  <= '0;
            r_image_width <= IMAGE_WIDTH_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_FRAME_BASE:  r_frame_base  <= i_cfg_data;
                REG_IMAGE_WIDTH: r_image_width <= i_cfg_data[WIDTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // line stepping
    lpr_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_cmd.valid),
        .o_ready     (i_cmd.ready),
        .i_cmd       (i_cmd.cmd),
        .i_x_start   (i_cmd.x_start),
        .i_y_start   (i_cmd.y_start),
        .i_x_end     (i_cmd.x_end),
        .i_y_end     (i_cmd.y_end),
        .i_pen_color (i_cmd.pen_color),
        .o_s1_valid  (s1_valid),
        .i_s1_ready  (s1_ready),
        .o_s1_x      (s1_x),
        .o_s1_y      (s1_y),
        .o_s1_color  (s1_color),
        .o_s1_last   (s1_last)
    );

    // address and output register
    lpr_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame_base    (r_frame_base),
        .i_image_width   (r_image_width),
        .i_s1_valid      (s1_valid),
        .o_s1_ready      (s1_ready),
        .i_s1_x          (s1_x),
        .i_s1_y          (s1_y),
        .i_s1_color      (s1_color),
        .i_s1_last       (s1_last),
        .o_valid         (o_pixel.valid),
        .i_ready         (o_pixel.ready),
        .o_pixel_address (o_pixel.pixel_address),
        .o_pixel_x       (o_pixel.pixel_x),
        .o_pixel_y       (o_pixel.pixel_y),
        .o_pixel_color   (o_pixel.pixel_color),
        .o_last_pixel    (o_pixel.last_pixel)
    );

endmodule

### design/lpr_stepper.sv
// ----------------------------------------------------------------------------
// lpr_stepper
// line state and dda error update, one command word per cycle unless the pixel
// stage stalls, registered pixel position stage toward the address stage
// ----------------------------------------------------------------------------
module lpr_stepper
    import lpr_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command word
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  logic [COLOR_BITS-1:0] i_pen_color,
    // pixel position word
    output logic                  o_s1_valid,
    input  logic                  i_s1_ready,
    output logic [COORD_BITS-1:0] o_s1_x,
    output logic [COORD_BITS-1:0] o_s1_y,
    output logic [COLOR_BITS-1:0] o_s1_color,
    output logic                  o_s1_last
);

    localparam int ERR_BITS = COORD_BITS + 1;

    // line state
    logic [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic [ERR_BITS-1:0]   r_x_error, n_x_error;
    logic [ERR_BITS-1:0]   r_y_error, n_y_error;
    logic [COORD_BITS-1:0] r_abs_dx, n_abs_dx;
    logic [COORD_BITS-1:0] r_abs_dy, n_abs_dy;
    logic [COORD_BITS-1:0] r_major_len, n_major_len;
    t_dir                  r_x_dir, n_x_dir;
    t_dir                  r_y_dir, n_y_dir;
    logic [COORD_BITS-1:0] r_steps_left, n_steps_left;
    logic                  r_line_active, n_line_active;
    logic [COLOR_BITS-1:0] r_line_color, n_line_color;

    // pixel stage
    logic                  r_s1_valid;
    logic [COORD_BITS-1:0] r_s1_x;
    logic [COORD_BITS-1:0] r_s1_y;
    logic [COLOR_BITS-1:0] r_s1_color;
    logic                  r_s1_last;

    logic                  accept;
    logic                  n_emit;
    logic [ERR_BITS-1:0]   x_sum;
    logic [ERR_BITS-1:0]   y_sum;
    logic [ERR_BITS-1:0]   major_ext;

    // one step of a position toward the end point
    function automatic logic [COORD_BITS-1:0] move_axis(
        input logic [COORD_BITS-1:0] pos,
        input t_dir                  dir
    );
        logic [COORD_BITS-1:0] res;
        unique case (dir)
            DIR_PLUS:  res = pos + COORD_BITS'(1);
            DIR_MINUS: res = pos - COORD_BITS'(1);
            default:   res = pos;
        endcase
        return res;
    endfunction

    assign o_ready = !r_s1_valid || i_s1_ready;
    assign accept  = i_valid && o_ready;

    assign major_ext = {1'b0, r_major_len};
    assign x_sum     = r_x_error + {1'b0, r_abs_dx};
    assign y_sum     = r_y_error + {1'b0, r_abs_dy};

    // next line state
    always_comb begin
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_x_error     = r_x_error;
        n_y_error     = r_y_error;
        n_abs_dx      = r_abs_dx;
        n_abs_dy      = r_abs_dy;
        n_major_len   = r_major_len;
        n_x_dir       = r_x_dir;
        n_y_dir       = r_y_dir;
        n_steps_left  = r_steps_left;
        n_line_active = r_line_active;
        n_line_color  = r_line_color;
        n_emit        = 1'b0;
        if (accept) begin
            if (i_cmd == CMD_START) begin
                // x axis delta and direction
                if (i_x_end > i_x_start) begin
                    n_abs_dx = i_x_end - i_x_start;
                    n_x_dir  = DIR_PLUS;
                end else if (i_x_end < i_x_start) begin
                    n_abs_dx = i_x_start - i_x_end;
                    n_x_dir  = DIR_MINUS;
                end else begin
                    n_abs_dx = '0;
                    n_x_dir  = DIR_NONE;
                end
                // y axis delta and direction
                if (i_y_end > i_y_start) begin
                    n_abs_dy = i_y_end - i_y_start;
                    n_y_dir  = DIR_PLUS;
                end else if (i_y_end < i_y_start) begin
                    n_abs_dy = i_y_start - i_y_end;
                    n_y_dir  = DIR_MINUS;
                end else begin
                    n_abs_dy = '0;
                    n_y_dir  = DIR_NONE;
                end
                n_major_len   = (n_abs_dx > n_abs_dy) ? n_abs_dx : n_abs_dy;
                n_cur_x       = i_x_start;
                n_cur_y       = i_y_start;
                n_x_error     = '0;
                n_y_error     = '0;
                n_line_color  = i_pen_color;
                n_steps_left  = n_major_len;
                n_line_active = (n_major_len != '0);
                n_emit        = 1'b1;
            end else if (r_line_active) begin
                n_x_error = x_sum;
                n_y_error = y_sum;
                if (x_sum >= major_ext) begin
                    n_cur_x   = move_axis(r_cur_x, r_x_dir);
                    n_x_error = x_sum - major_ext;
                end
                if (y_sum >= major_ext) begin
                    n_cur_y   = move_axis(r_cur_y, r_y_dir);
                    n_y_error = y_sum - major_ext;
                end
                n_steps_left  = r_steps_left - COORD_BITS'(1);
                n_line_active = (n_steps_left != '0);
                n_emit        = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_x_error     <= '0;
            r_y_error     <= '0;
            r_abs_dx      <= '0;
            r_abs_dy      <= '0;
            r_major_len   <= '0;
            r_x_dir       <= DIR_NONE;
            r_y_dir       <= DIR_NONE;
            r_steps_left  <= '0;
            r_line_color  <= '0;
        end else begin
            r_line_active <= n_line_active;
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_x_error     <= n_x_error;
            r_y_error     <= n_y_error;
            r_abs_dx      <= n_abs_dx;
            r_abs_dy      <= n_abs_dy;
            r_major_len   <= n_major_len;
            r_x_dir       <= n_x_dir;
            r_y_dir       <= n_y_dir;
            r_steps_left  <= n_steps_left;
            r_line_color  <= n_line_color;
        end
    end

    // pixel stage toward the address unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= n_emit;
        end else if (i_s1_ready) begin
            r_s1_valid <= 1'b0;
        end
        if (accept && n_emit) begin
            r_s1_x     <= n_cur_x;
            r_s1_y     <= n_cur_y;
            r_s1_color <= n_line_color;
            r_s1_last  <= !n_line_active;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_x     = r_s1_x;
    assign o_s1_y     = r_s1_y;
    assign o_s1_color = r_s1_color;
    assign o_s1_last  = r_s1_last;

    // an active line always has steps to go and a nonzero major length
    a_active_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_major_len != '0) && (r_steps_left != '0))
        else $error("active line with zero length or no steps left");

    // steps left never exceed the line length
    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_steps_left <= r_major_len))
        else $error("steps left beyond line length");

    // errors stay below the major length while stepping
    a_err_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_x_error < major_ext) && (r_y_error < major_ext))
        else $error("axis error reached major length");

    // a stalled pixel word is not dropped
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !i_s1_ready) |=> r_s1_valid && $stable(r_s1_x)
            && $stable(r_s1_y))
        else $error("stalled pixel word lost");

endmodule

### design/lpr_addr.sv
// ----------------------------------------------------------------------------
// lpr_addr
// framebuffer byte address of a pixel and the output register
// ----------------------------------------------------------------------------
module lpr_addr
    import lpr_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [ADDR_BITS-1:0]  i_frame_base,
    input  logic [WIDTH_BITS-1:0] i_image_width,
    // pixel position word
    input  logic                  i_s1_valid,
    output logic                  o_s1_ready,
    input  logic [COORD_BITS-1:0] i_s1_x,
    input  logic [COORD_BITS-1:0] i_s1_y,
    input  logic [COLOR_BITS-1:0] i_s1_color,
    input  logic                  i_s1_last,
    // pixel word out
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [ADDR_BITS-1:0]  o_pixel_address,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [COLOR_BITS-1:0] o_pixel_color,
    output logic                  o_last_pixel
);

    localparam int PROD_BITS = COORD_BITS + WIDTH_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;

    logic                  r_valid;
    logic [ADDR_BITS-1:0]  r_pixel_address;
    logic [COORD_BITS-1:0] r_pixel_x;
    logic [COORD_BITS-1:0] r_pixel_y;
    logic [COLOR_BITS-1:0] r_pixel_color;
    logic                  r_last_pixel;

    logic                  take;
    logic [PROD_BITS-1:0]  row_offset;
    logic [SUM_BITS-1:0]   pixel_index;
    logic [ADDR_BITS-1:0]  n_pixel_address;

    assign o_s1_ready = !r_valid || i_ready;
    assign take       = i_s1_valid && o_s1_ready;

    // base + 2 * (y * width + x), wrapping at the address width
    assign row_offset      = PROD_BITS'(i_s1_y) * PROD_BITS'(i_image_width);
    assign pixel_index     = SUM_BITS'(row_offset) + SUM_BITS'(i_s1_x);
    assign n_pixel_address = i_frame_base + ADDR_BITS'({pixel_index, 1'b0});

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (take) begin
            r_pixel_address <= n_pixel_address;
            r_pixel_x       <= i_s1_x;
            r_pixel_y       <= i_s1_y;
            r_pixel_color   <= i_s1_color;
            r_last_pixel    <= i_s1_last;
        end
    end

    assign o_valid         = r_valid;
    assign o_pixel_address = r_pixel_address;
    assign o_pixel_x       = r_pixel_x;
    assign o_pixel_y       = r_pixel_y;
    assign o_pixel_color   = r_pixel_color;
    assign o_last_pixel    = r_last_pixel;

endmodule
